@@ sv/lcar_pkg.sv @@
`default_nettype none

package lcar_pkg;

   localparam int DATA_BITS_DEF = 24;

   localparam logic [1:0] KIND_TARE   = 2'd1;
   localparam logic [1:0] KIND_WEIGHT = 2'd2;

   localparam logic [1:0] REG_SCALE  = 2'd0;
   localparam logic [1:0] REG_OFFSET = 2'd1;
   localparam logic [1:0] REG_EXTRA  = 2'd2;

   localparam logic [31:0] SCALE_RST  = 32'd79810;
   localparam logic [31:0] OFFSET_RST = 32'd0;
   localparam logic [1:0]  EXTRA_RST  = 2'd1;

   typedef logic [47:0] value_type;

   localparam value_type VALUE_MAX = {1'b0, {47{1'b1}}};
   localparam value_type VALUE_MIN = {1'b1, {47{1'b0}}};

   typedef struct packed {
      logic sck;
      logic done;
      logic was_tare;
      logic timed_out;
      logic direct;
   } lcar_tag_type;

endpackage

`default_nettype wire

@@ sv/lcar_ifs.sv @@
`default_nettype none

interface lcar_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic       dout;

   modport source (output valid, output kind, output dout, input ready);
   modport sink   (input valid, input kind, input dout, output ready);
endinterface

interface lcar_rsp_if;
   logic        valid;
   logic        ready;
   logic        sck;
   logic        done_res;
   logic [47:0] value;
   logic        was_tare;
   logic        timed_out;

   modport source (output valid, output sck, output done_res, output value,
                   output was_tare, output timed_out, input ready);
   modport sink   (input valid, input sck, input done_res, input value,
                   input was_tare, input timed_out, output ready);
endinterface

interface lcar_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [31:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ sv/lcar_seq.sv @@
`default_nettype none

module lcar_seq
   import lcar_pkg::*;
#(
   parameter int DATA_BITS = DATA_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   lcar_req_if.sink                  req,
   input  wire logic [1:0]           extra_pulses,
   output      logic                 s1_valid,
   input  wire logic                 s1_ready,
   output      lcar_tag_type         s1_tag,
   output      logic [DATA_BITS-1:0] s1_raw
);

   localparam int BC_W = $clog2(DATA_BITS + 1);

   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_WAIT = 3'd1;
   localparam logic [2:0] PH_DHI  = 3'd2;
   localparam logic [2:0] PH_DLO  = 3'd3;
   localparam logic [2:0] PH_PHI  = 3'd4;
   localparam logic [2:0] PH_PLO  = 3'd5;

   localparam logic [DATA_BITS-1:0] MSB_FLIP = {1'b1, {(DATA_BITS-1){1'b0}}};

   logic                 s0_valid_ff;
   logic [1:0]           s0_kind_ff;
   logic                 s0_dout_ff;
   logic                 s1_valid_ff;
   lcar_tag_type         s1_tag_ff, s1_tag_in;
   logic [DATA_BITS-1:0] s1_raw_ff, s1_raw_in;

   logic [2:0]           phase_ff, phase_in;
   logic [BC_W-1:0]      bit_count_ff, bit_count_in;
   logic [DATA_BITS-1:0] shift_data_ff, shift_data_in;
   logic [1:0]           wait_count_ff, wait_count_in;
   logic [1:0]           pulse_count_ff, pulse_count_in;
   logic                 pending_tare_ff, pending_tare_in;
   logic                 tare_taken_ff, tare_taken_in;

   logic s1_free, s0_free, step;

   assign s1_free   = !s1_valid_ff || s1_ready;
   assign s0_free   = !s0_valid_ff || s1_free;
   assign step      = s0_valid_ff && s1_free;
   assign req.ready = s0_free;

   assign s1_valid = s1_valid_ff;
   assign s1_tag   = s1_tag_ff;
   assign s1_raw   = s1_raw_ff;

   always_comb begin
      logic [DATA_BITS-1:0] shift_next;
      logic [BC_W-1:0]      bit_inc;
      logic [1:0]           wait_inc;
      logic [1:0]           pulse_inc;
      logic                 fin;
      logic                 tmo;

      shift_next      = {shift_data_ff[DATA_BITS-2:0], s0_dout_ff};
      bit_inc         = bit_count_ff + BC_W'(1);
      wait_inc        = wait_count_ff + 2'd1;
      pulse_inc       = pulse_count_ff + 2'd1;
      fin             = 1'b0;
      tmo             = 1'b0;
      phase_in        = phase_ff;
      bit_count_in    = bit_count_ff;
      shift_data_in   = shift_data_ff;
      wait_count_in   = wait_count_ff;
      pulse_count_in  = pulse_count_ff;
      pending_tare_in = pending_tare_ff;
      tare_taken_in   = tare_taken_ff;
      s1_tag_in       = '0;
      s1_raw_in       = '0;

      case (phase_ff)
         PH_IDLE: begin
            if (s0_kind_ff == KIND_WEIGHT && !tare_taken_ff) begin
               s1_tag_in.done   = 1'b1;
               s1_tag_in.direct = 1'b1;
            end else if (s0_kind_ff inside {KIND_TARE, KIND_WEIGHT}) begin
               pending_tare_in = (s0_kind_ff == KIND_TARE);
               bit_count_in    = '0;
               shift_data_in   = '0;
               pulse_count_in  = '0;
               if (!s0_dout_ff) begin
                  wait_count_in = 2'd0;
                  phase_in      = PH_DHI;
               end else begin
                  wait_count_in = 2'd1;
                  phase_in      = PH_WAIT;
               end
            end
         end
         PH_WAIT: begin
            if (!s0_dout_ff) begin
               phase_in = PH_DHI;
            end else begin
               wait_count_in = wait_inc;
               if (wait_inc >= 2'd2) begin
                  fin = 1'b1;
                  tmo = 1'b1;
               end
            end
         end
         PH_DHI: begin
            s1_tag_in.sck = 1'b1;
            phase_in      = PH_DLO;
         end
         PH_DLO: begin
            shift_data_in = shift_next;
            bit_count_in  = bit_inc;
            if (bit_inc >= BC_W'(DATA_BITS)) begin
               if (extra_pulses == 2'd0) begin
                  fin       = 1'b1;
                  s1_raw_in = shift_next ^ MSB_FLIP;
               end else begin
                  pulse_count_in = 2'd0;
                  phase_in       = PH_PHI;
               end
            end else begin
               phase_in = PH_DHI;
            end
         end
         PH_PHI: begin
            s1_tag_in.sck = 1'b1;
            phase_in      = PH_PLO;
         end
         PH_PLO: begin
            pulse_count_in = pulse_inc;
            if (pulse_inc >= extra_pulses) begin
               fin       = 1'b1;
               s1_raw_in = shift_data_ff ^ MSB_FLIP;
            end else begin
               phase_in = PH_PHI;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      if (fin) begin
         s1_tag_in.done      = 1'b1;
         s1_tag_in.was_tare  = pending_tare_ff;
         s1_tag_in.timed_out = tmo;
         phase_in            = PH_IDLE;
         if (pending_tare_ff) begin
            tare_taken_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff     <= 1'b0;
         s1_valid_ff     <= 1'b0;
         phase_ff        <= PH_IDLE;
         bit_count_ff    <= '0;
         shift_data_ff   <= '0;
         wait_count_ff   <= '0;
         pulse_count_ff  <= '0;
         pending_tare_ff <= 1'b0;
         tare_taken_ff   <= 1'b0;
      end else begin
         if (s0_free) begin
            s0_valid_ff <= req.valid;
         end
         if (s1_free) begin
            s1_valid_ff <= s0_valid_ff;
         end
         if (step) begin
            phase_ff        <= phase_in;
            bit_count_ff    <= bit_count_in;
            shift_data_ff   <= shift_data_in;
            wait_count_ff   <= wait_count_in;
            pulse_count_ff  <= pulse_count_in;
            pending_tare_ff <= pending_tare_in;
            tare_taken_ff   <= tare_taken_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && s0_free) begin
         s0_kind_ff <= req.kind;
         s0_dout_ff <= req.dout;
      end
      if (step) begin
         s1_tag_ff <= s1_tag_in;
         s1_raw_ff <= s1_raw_in;
      end
   end

`ifndef SYNTHESIS
   a_bit_count_range: assert property (@(posedge clock) disable iff (reset)
      bit_count_ff <= BC_W'(DATA_BITS))
      else $error("bit count beyond word length");

   a_high_then_low: assert property (@(posedge clock) disable iff (reset)
      step && (phase_ff == PH_DHI || phase_ff == PH_PHI) |=>
         phase_ff == PH_DLO || phase_ff == PH_PLO)
      else $error("clock high tick not followed by low tick");

   a_timeout_raw: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_tag_ff.timed_out |-> s1_raw_ff == '0 && s1_tag_ff.done)
      else $error("timed-out word carries data");

   a_direct_no_tare: assert property (@(posedge clock) disable iff (reset)
      step && s1_tag_in.direct |-> !tare_taken_ff && phase_ff == PH_IDLE)
      else $error("direct result after tare taken");
`endif

endmodule

`default_nettype wire

@@ sv/lcar_arith.sv @@
`default_nettype none

module lcar_arith
   import lcar_pkg::*;
#(
   parameter int DATA_BITS = DATA_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 s1_valid,
   output      logic                 s1_ready,
   input  wire lcar_tag_type         s1_tag,
   input  wire logic [DATA_BITS-1:0] s1_raw,
   input  wire logic [31:0]          scale,
   input  wire logic [31:0]          offset,
   lcar_rsp_if.source                rsp
);

   localparam int PW = DATA_BITS + 32;
   localparam int QW = DATA_BITS + 24;
   localparam int SW = (QW + 2 > 50) ? QW + 2 : 50;

   logic          s2_valid_ff, s3_valid_ff, s4_valid_ff;
   lcar_tag_type  s2_tag_ff, s3_tag_ff, s4_tag_ff;
   logic [PW-1:0] prod_ff, prod_in;
   value_type     w_ff, w_in;
   value_type     value_ff, value_in;
   value_type     tare_value_ff, tare_value_in;

   logic s2_free, s3_free, s4_free;

   assign s4_free  = !s4_valid_ff || rsp.ready;
   assign s3_free  = !s3_valid_ff || s4_free;
   assign s2_free  = !s2_valid_ff || s3_free;
   assign s1_ready = s2_free;

   assign prod_in = PW'(s1_raw) * PW'(scale);

   always_comb begin
      logic [PW-1:0]  rnd;
      logic [QW-1:0]  q16;
      logic [SW-1:0]  sum;
      logic [SW-48:0] hi;

      rnd = prod_ff + PW'(128);
      q16 = rnd[PW-1:8];
      sum = {{(SW-QW){1'b0}}, q16} + {{(SW-32){offset[31]}}, offset};
      hi  = sum[SW-1:47];
      if ((&hi) || !(|hi)) begin
         w_in = sum[47:0];
      end else if (sum[SW-1]) begin
         w_in = VALUE_MIN;
      end else begin
         w_in = VALUE_MAX;
      end
   end

   always_comb begin
      logic [48:0] diff;

      diff          = {w_ff[47], w_ff} - {tare_value_ff[47], tare_value_ff};
      tare_value_in = tare_value_ff;
      value_in      = '0;
      if (s3_tag_ff.done && !s3_tag_ff.direct) begin
         if (s3_tag_ff.was_tare) begin
            value_in      = w_ff;
            tare_value_in = w_ff;
         end else if (diff[48] != diff[47]) begin
            value_in = diff[48] ? VALUE_MIN : VALUE_MAX;
         end else begin
            value_in = diff[47:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff   <= 1'b0;
         s3_valid_ff   <= 1'b0;
         s4_valid_ff   <= 1'b0;
         tare_value_ff <= '0;
      end else begin
         if (s2_free) begin
            s2_valid_ff <= s1_valid;
         end
         if (s3_free) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (s4_free) begin
            s4_valid_ff <= s3_valid_ff;
         end
         if (s4_free && s3_valid_ff) begin
            tare_value_ff <= tare_value_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_free && s1_valid) begin
         s2_tag_ff <= s1_tag;
         prod_ff   <= prod_in;
      end
      if (s3_free && s2_valid_ff) begin
         s3_tag_ff <= s2_tag_ff;
         w_ff      <= w_in;
      end
      if (s4_free && s3_valid_ff) begin
         s4_tag_ff <= s3_tag_ff;
         value_ff  <= value_in;
      end
   end

   assign rsp.valid     = s4_valid_ff;
   assign rsp.sck       = s4_tag_ff.sck;
   assign rsp.done_res  = s4_tag_ff.done;
   assign rsp.value     = value_ff;
   assign rsp.was_tare  = s4_tag_ff.was_tare;
   assign rsp.timed_out = s4_tag_ff.timed_out;

`ifndef SYNTHESIS
   a_idle_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.done_res |-> rsp.value == '0 && !rsp.was_tare && !rsp.timed_out)
      else $error("word without result carries value");

   a_tare_update: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$stable(tare_value_ff) |-> rsp.valid && rsp.was_tare)
      else $error("tare changed without tare result");

   a_tare_echo: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.was_tare |-> rsp.value == tare_value_ff)
      else $error("tare result differs from stored tare");
`endif

endmodule

`default_nettype wire

@@ sv/load_cell_adc_reader_top.sv @@
`default_nettype none

// Load-cell converter reader. Each req word is one tick of the two-wire link
// (kind 0) or a tare (1) or weight (2) request, with the sampled data line
// level; every req word yields exactly one rsp word carrying the clock level
// to drive and, on the closing tick of a read, the Q32.16 result. One word is
// taken every cycle unless rsp stalls; a result passes through the input
// register, the sequencer stage, the raw-by-scale multiplier and the rounding,
// offset and tare saturation stages before it is offered. Write scale, offset
// and extra_pulses only while no word is in flight.
module load_cell_adc_reader_top
   import lcar_pkg::*;
#(
   parameter int DATA_BITS = DATA_BITS_DEF
) (
   input wire logic   clock,
   input wire logic   reset,
   lcar_req_if.sink   req_ch,
   lcar_rsp_if.source rsp_ch,
   lcar_csr_if.sink   csr_ch
);

   logic [31:0] scale_ff;
   logic [31:0] offset_ff;
   logic [1:0]  extra_pulses_ff;

   logic                 s1_valid;
   logic                 s1_ready;
   lcar_tag_type         s1_tag;
   logic [DATA_BITS-1:0] s1_raw;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff        <= SCALE_RST;
         offset_ff       <= OFFSET_RST;
         extra_pulses_ff <= EXTRA_RST;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            REG_SCALE:  scale_ff        <= csr_ch.data;
            REG_OFFSET: offset_ff       <= csr_ch.data;
            REG_EXTRA:  extra_pulses_ff <= csr_ch.data[1:0];
            default: begin
            end
         endcase
      end
   end

   lcar_seq #(
      .DATA_BITS (DATA_BITS)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .req          (req_ch),
      .extra_pulses (extra_pulses_ff),
      .s1_valid     (s1_valid),
      .s1_ready     (s1_ready),
      .s1_tag       (s1_tag),
      .s1_raw       (s1_raw)
   );

   lcar_arith #(
      .DATA_BITS (DATA_BITS)
   ) u_arith (
      .clock    (clock),
      .reset    (reset),
      .s1_valid (s1_valid),
      .s1_ready (s1_ready),
      .s1_tag   (s1_tag),
      .s1_raw   (s1_raw),
      .scale    (scale_ff),
      .offset   (offset_ff),
      .rsp      (rsp_ch)
   );

endmodule

`default_nettype wire

@@ bench/tb_load_cell_adc_reader_top.sv @@
`default_nettype none

module tb_load_cell_adc_reader_top
   import lcar_pkg::*;
();

   localparam int DATA_BITS = DATA_BITS_DEF;
   localparam int CYCLE_LIMIT = 250000;
   localparam int RANDOM_BATCHES = 2;
   localparam int RANDOM_BATCH_WORDS = 30;

   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_SPARE = 2'd3;

   localparam longint MAX48 = 64'sh0000_7fff_ffff_ffff;
   localparam longint MIN48 = -MAX48 - 64'sd1;

   localparam logic [DATA_BITS-1:0] SIGN_FLIP = {1'b1, {(DATA_BITS - 1){1'b0}}};

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_WAIT,
      PH_DHI,
      PH_DLO,
      PH_PHI,
      PH_PLO
   } link_phase_type;

   typedef struct packed {
      logic        sck;
      logic        done;
      logic [47:0] value;
      logic        was_tare;
      logic        timed_out;
   } reader_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lcar_req_if req_ch ();
   lcar_rsp_if rsp_ch ();
   lcar_csr_if csr_ch ();

   load_cell_adc_reader_top i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #1 clock = ~clock;

   logic [31:0]          cfg_scale;
   logic [31:0]          cfg_offset;
   logic [1:0]           cfg_pulses;

   link_phase_type       link_phase;
   int                   bits_in;
   logic [DATA_BITS-1:0] shift_word;
   logic [1:0]           wait_cnt;
   logic [1:0]           pulse_cnt;
   logic                 tare_pending;
   logic [47:0]          tare_val;
   logic [47:0]          net_val;
   logic                 tare_held;

   reader_word_type reader_words[$];

   bit send_idle = 1'b1;
   bit recv_idle = 1'b1;
   int hold_req = 0;
   int hold_left = 0;
   int stall_left = 0;

   int fails = 0;
   int words_sent = 0;
   int reads_done = 0;
   int tares_done = 0;
   int timeouts_seen = 0;
   int cycle_count = 0;

   function automatic logic [47:0] clamp48(input longint v);
      if (v > MAX48) return VALUE_MAX;
      if (v < MIN48) return VALUE_MIN;
      return v[47:0];
   endfunction

   function automatic longint scaled_reading(input logic [DATA_BITS-1:0] raw);
      logic [63:0] prod;
      logic [63:0] q16;
      longint      off;
      prod = 64'(raw) * 64'(cfg_scale);
      q16 = (prod + 64'd128) >> 8;
      off = longint'($signed(cfg_offset));
      return longint'(q16) + off;
   endfunction

   task automatic finish_read(input logic [DATA_BITS-1:0] raw, input logic tmo,
                              inout reader_word_type w);
      logic [47:0] reading;
      reading = clamp48(scaled_reading(raw));
      if (tare_pending) begin
         tare_val = reading;
         tare_held = 1'b1;
         w.value = reading;
      end else begin
         net_val = clamp48(longint'($signed(reading)) - longint'($signed(tare_val)));
         w.value = net_val;
      end
      w.done = 1'b1;
      w.was_tare = tare_pending;
      w.timed_out = tmo;
      link_phase = PH_IDLE;
   endtask

   task automatic advance_reader(input logic [1:0] kind, input logic d,
                                 output reader_word_type w);
      w = '0;
      case (link_phase)
         PH_IDLE: begin
            if (kind == KIND_WEIGHT && !tare_held) begin
               w.done = 1'b1;
               w.value = net_val;
            end else if (kind == KIND_TARE || kind == KIND_WEIGHT) begin
               tare_pending = (kind == KIND_TARE);
               bits_in = 0;
               shift_word = '0;
               pulse_cnt = '0;
               if (!d) begin
                  wait_cnt = 2'd0;
                  link_phase = PH_DHI;
               end else begin
                  wait_cnt = 2'd1;
                  link_phase = PH_WAIT;
               end
            end
         end
         PH_WAIT: begin
            if (!d) begin
               link_phase = PH_DHI;
            end else begin
               wait_cnt = wait_cnt + 2'd1;
               if (wait_cnt >= 2'd2) finish_read('0, 1'b1, w);
            end
         end
         PH_DHI: begin
            w.sck = 1'b1;
            link_phase = PH_DLO;
         end
         PH_DLO: begin
            shift_word = {shift_word[DATA_BITS-2:0], d};
            bits_in++;
            if (bits_in >= DATA_BITS) begin
               if (cfg_pulses == 2'd0) begin
                  finish_read(shift_word ^ SIGN_FLIP, 1'b0, w);
               end else begin
                  pulse_cnt = '0;
                  link_phase = PH_PHI;
               end
            end else begin
               link_phase = PH_DHI;
            end
         end
         PH_PHI: begin
            w.sck = 1'b1;
            link_phase = PH_PLO;
         end
         PH_PLO: begin
            pulse_cnt = pulse_cnt + 2'd1;
            if (pulse_cnt >= cfg_pulses) finish_read(shift_word ^ SIGN_FLIP, 1'b0, w);
            else link_phase = PH_PHI;
         end
         default: begin
            link_phase = PH_IDLE;
         end
      endcase
   endtask

   always @(negedge clock) begin
      if (hold_req > 0) begin
         hold_left = hold_req;
         hold_req = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready = 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ch.ready = 1'b0;
      end else if (recv_idle && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(1, 19) - 1;
         rsp_ch.ready = 1'b0;
      end else begin
         rsp_ch.ready = 1'b1;
      end
   end

   task automatic check_field(input string name, input logic [47:0] want,
                              input logic [47:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         fails++;
      end
   endtask

   always @(posedge clock) begin
      reader_word_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (reader_words.size() == 0) begin
            $error("rsp word with nothing outstanding");
            fails++;
         end else begin
            want = reader_words.pop_front();
            check_field("sck", 48'(want.sck), 48'(rsp_ch.sck));
            check_field("done_res", 48'(want.done), 48'(rsp_ch.done_res));
            check_field("value", want.value, rsp_ch.value);
            check_field("was_tare", 48'(want.was_tare), 48'(rsp_ch.was_tare));
            check_field("timed_out", 48'(want.timed_out), 48'(rsp_ch.timed_out));
            if (want.done) reads_done++;
            if (want.done && want.was_tare) tares_done++;
            if (want.timed_out) timeouts_seen++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic send_word(input logic [1:0] kind, input logic dout);
      reader_word_type w;
      int gap;
      gap = (send_idle && $urandom_range(0, 9) == 0) ? $urandom_range(1, 19) : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_ch.valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_ch.valid = 1'b1;
      req_ch.kind = kind;
      req_ch.dout = dout;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      advance_reader(kind, dout, w);
      reader_words.push_back(w);
      words_sent++;
   endtask

   task automatic quiesce();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (reader_words.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] index, input logic [31:0] data);
      quiesce();
      @(negedge clock);
      csr_ch.valid = 1'b1;
      csr_ch.index = index;
      csr_ch.data = data;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      case (index)
         REG_SCALE:  cfg_scale = data;
         REG_OFFSET: cfg_offset = data;
         REG_EXTRA:  cfg_pulses = data[1:0];
         default:    ;
      endcase
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   // looks: 0 data already low, 1 one high look first, 2 converter never ready
   task automatic take_reading(input logic [1:0] kind, input int looks,
                               input logic [DATA_BITS-1:0] word, input bit noisy);
      logic [1:0] k;
      logic       d;
      send_word(kind, looks > 0);
      while (link_phase != PH_IDLE) begin
         k = KIND_TICK;
         if (noisy && $urandom_range(0, 3) == 0) k = 2'($urandom_range(0, 3));
         case (link_phase)
            PH_WAIT: d = (looks >= 2);
            PH_DLO:  d = word[DATA_BITS - 1 - bits_in];
            default: d = 1'($urandom_range(0, 1));
         endcase
         send_word(k, d);
      end
   endtask

   task automatic test_weight_without_tare();
      send_word(KIND_WEIGHT, 1'b0);
      send_word(KIND_WEIGHT, 1'b1);
      send_word(KIND_SPARE, 1'b1);
      send_word(KIND_TICK, 1'b0);
      send_word(KIND_TICK, 1'b1);
   endtask

   task automatic test_data_extremes();
      take_reading(KIND_TARE, 0, '0, 1'b0);
      take_reading(KIND_WEIGHT, 1, '1, 1'b0);
   endtask

   task automatic test_saturation();
      write_reg(REG_SCALE, 32'hffff_ffff);
      write_reg(REG_OFFSET, 32'h7fff_ffff);
      take_reading(KIND_TARE, 0, '1, 1'b0);
      write_reg(REG_SCALE, 32'd0);
      write_reg(REG_OFFSET, 32'h8000_0000);
      take_reading(KIND_WEIGHT, 0, '0, 1'b0);
   endtask

   task automatic test_pulse_counts();
      write_reg(REG_SCALE, SCALE_RST);
      write_reg(REG_OFFSET, 32'h0001_0000);
      for (int p = 0; p < 4; p += 3) begin
         write_reg(REG_EXTRA, 32'(p));
         take_reading(KIND_WEIGHT, 0, DATA_BITS'($urandom), 1'b0);
      end
      write_reg(REG_EXTRA, 32'(EXTRA_RST));
   endtask

   task automatic test_timeouts();
      write_reg(REG_OFFSET, 32'hfff0_8000);
      take_reading(KIND_TARE, 2, '1, 1'b0);
      take_reading(KIND_WEIGHT, 2, '1, 1'b0);
      take_reading(KIND_WEIGHT, 1, DATA_BITS'($urandom), 1'b0);
   endtask

   task automatic test_busy_requests();
      take_reading(KIND_WEIGHT, 1, DATA_BITS'($urandom), 1'b1);
   endtask

   task automatic test_output_backpressure();
      send_idle = 1'b0;
      hold_req = 250;
      take_reading(KIND_WEIGHT, 0, DATA_BITS'($urandom), 1'b0);
      repeat (10) send_word(KIND_TICK, 1'($urandom_range(0, 1)));
      send_idle = 1'b1;
   endtask

   task automatic test_random_reads();
      int start;
      int pick;
      int looks;
      for (int batch = 0; batch < RANDOM_BATCHES; batch++) begin
         write_reg(REG_SCALE, ($urandom_range(0, 3) == 0) ? $urandom
                                                         : $urandom_range(1, 200000));
         write_reg(REG_OFFSET, $urandom);
         write_reg(REG_EXTRA, 32'($urandom_range(0, 3)));
         if (batch == RANDOM_BATCHES - 1) begin
            send_idle = 1'b0;
            recv_idle = 1'b0;
         end
         start = words_sent;
         while (words_sent - start < RANDOM_BATCH_WORDS) begin
            if ($urandom_range(0, 7) == 0) begin
               send_word($urandom_range(0, 1) ? KIND_TICK : KIND_SPARE,
                         1'($urandom_range(0, 1)));
            end else begin
               pick = $urandom_range(0, 9);
               looks = (pick < 6) ? 0 : (pick < 8) ? 1 : 2;
               take_reading(($urandom_range(0, 2) == 0) ? KIND_TARE : KIND_WEIGHT, looks,
                            DATA_BITS'($urandom), $urandom_range(0, 4) == 0);
            end
         end
      end
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.kind = KIND_TICK;
      req_ch.dout = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = REG_SCALE;
      csr_ch.data = '0;
      rsp_ch.ready = 1'b0;

      cfg_scale = SCALE_RST;
      cfg_offset = OFFSET_RST;
      cfg_pulses = EXTRA_RST;
      link_phase = PH_IDLE;
      bits_in = 0;
      shift_word = '0;
      wait_cnt = '0;
      pulse_cnt = '0;
      tare_pending = 1'b0;
      tare_val = '0;
      net_val = '0;
      tare_held = 1'b0;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_weight_without_tare();
      test_data_extremes();
      test_saturation();
      test_pulse_counts();
      test_timeouts();
      test_busy_requests();
      test_output_backpressure();
      test_random_reads();
      quiesce();

      $display("Sent %0d req words; %0d reads completed, %0d of them tares, %0d timed out.",
               words_sent, reads_done, tares_done, timeouts_seen);
      $display("Covered zero and three extra pulses, saturating scale and offset, busy and");
      $display("spare requests, and a long rsp hold-off that stalled the req side.");
      if (fails == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

`default_nettype wire
